@@ rtl/core/uhr_pkg.sv @@
// uhr_pkg: shared types and constants of the undo history ring
// item and result structures, operation and status codes
// no dependencies
package uhr_pkg;

	localparam logic [31:0] FALLBACK_KEY_BIT = 32'h8000_0000;
	localparam logic [15:0] TIMEOUT_RESET    = 16'd300;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_BEGIN   = 2'd1,
		OP_CAPTURE = 2'd2,
		OP_RESTORE = 2'd3
	} op_t;

	localparam logic [2:0] ST_NONE         = 3'd0;
	localparam logic [2:0] ST_REJECTED     = 3'd1;
	localparam logic [2:0] ST_COALESCED    = 3'd2;
	localparam logic [2:0] ST_STORED       = 3'd3;
	localparam logic [2:0] ST_RESTORED     = 3'd4;
	localparam logic [2:0] ST_RESTORE_FAIL = 3'd5;

	typedef struct packed {
		op_t         op;
		logic [31:0] key;
		logic [31:0] now;
		logic        blocked;
		logic        ext_ok;
	} item_t;

	typedef struct packed {
		logic       ok;
		logic [2:0] status;
		logic [3:0] slot;
		logic [3:0] levels;
		logic       avail;
	} result_t;

endpackage

@@ rtl/core/uhr_queue.sv @@
// uhr_queue: two-entry queue between front and back
// depends on uhr_pkg for the item type
module uhr_queue
	import uhr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_data,
	output logic  full,
	input  logic  pop,
	output item_t pop_data,
	output logic  empty
);

	item_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_data;
	end

endmodule

@@ rtl/core/uhr_front.sv @@
// uhr_front: input acceptance and classification of items
// forms the key each operation needs; depends on uhr_pkg
module uhr_front
	import uhr_pkg::*;
(
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] gest_id,
	input  logic [7:0]  src_tag,
	input  logic [31:0] cur_tick,
	input  logic        blocked,
	input  logic        external_ok,
	input  logic        q_full,
	output logic        q_push,
	output item_t       q_data
);

	op_t cmd;

	assign cmd      = op_t'(op);
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_data.op      = cmd;
		q_data.now     = cur_tick;
		q_data.blocked = blocked;
		q_data.ext_ok  = external_ok;
		unique case (cmd)
			OP_BEGIN:   q_data.key = gest_id;
			OP_CAPTURE: q_data.key = FALLBACK_KEY_BIT | {24'd0, src_tag};
			OP_CLEAR,
			OP_RESTORE: q_data.key = 32'd0;
			default:    q_data.key = 32'd0;
		endcase
	end

endmodule

@@ rtl/core/uhr_back.sv @@
// uhr_back: executes items against the history ring and holds the result
// key and tick memories, ring pointers, latched key; depends on uhr_pkg
module uhr_back
	import uhr_pkg::*;
#(
	parameter int HISTORY_DEPTH = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] timeout,
	input  logic        q_empty,
	input  item_t       q_data,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     res
);

	localparam int IDX_W = $clog2(HISTORY_DEPTH);
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(HISTORY_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t           state_q;
	item_t            work_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] oldest_q;
	logic [31:0]      lkey_q;
	logic             lval_q;
	logic [31:0]      rd_key_q;
	logic [31:0]      rd_tick_q;
	logic             out_valid_q;
	result_t          res_q;

	logic [31:0]      key_mem  [HISTORY_DEPTH];
	logic [31:0]      tick_mem [HISTORY_DEPTH];

	logic [IDX_W-1:0] top;
	logic [IDX_W-1:0] push_idx;
	logic [CNT_W-1:0] nxt_count;
	logic [IDX_W-1:0] nxt_oldest;
	logic [31:0]      nxt_lkey;
	logic             nxt_lval;
	logic             do_push;
	logic [31:0]      cap_key;
	logic [31:0]      tick_diff;
	logic             hit;
	logic             nxt_ok;
	logic [2:0]       nxt_status;
	logic [IDX_W-1:0] nxt_slot;

	function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] v);
		logic [SUM_W-1:0] r;
		r = (v >= SUM_W'(HISTORY_DEPTH)) ? v - SUM_W'(HISTORY_DEPTH) : v;
		return r[IDX_W-1:0];
	endfunction

	assign q_pop     = (state_q == S_IDLE) && !q_empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_comb begin
		if (count_q == '0)
			top = '0;
		else
			top = wrap(SUM_W'(oldest_q) + SUM_W'(count_q) - SUM_W'(1));
	end

	assign cap_key   = lval_q ? lkey_q : work_q.key;
	assign tick_diff = work_q.now - rd_tick_q;
	assign hit       = (count_q != '0) && (rd_key_q == cap_key) &&
	                   (tick_diff <= {16'd0, timeout});

	always_comb begin
		nxt_count  = count_q;
		nxt_oldest = oldest_q;
		nxt_lkey   = lkey_q;
		nxt_lval   = lval_q;
		do_push    = 1'b0;
		push_idx   = '0;
		nxt_ok     = 1'b0;
		nxt_status = ST_NONE;
		nxt_slot   = '0;
		unique case (work_q.op)
			OP_CLEAR: begin
				nxt_count  = '0;
				nxt_oldest = '0;
				nxt_lkey   = '0;
				nxt_lval   = 1'b0;
			end
			OP_BEGIN: begin
				nxt_lkey = work_q.key;
				nxt_lval = 1'b1;
			end
			OP_CAPTURE: begin
				priority if (work_q.blocked) begin
					nxt_status = ST_REJECTED;
				end else if (hit) begin
					nxt_ok     = 1'b1;
					nxt_status = ST_COALESCED;
					nxt_slot   = top;
				end else if (!work_q.ext_ok) begin
					nxt_status = ST_REJECTED;
				end else begin
					do_push    = 1'b1;
					nxt_ok     = 1'b1;
					nxt_status = ST_STORED;
					priority if (count_q == '0) begin
						push_idx   = '0;
						nxt_oldest = '0;
						nxt_count  = CNT_W'(1);
					end else if (count_q < DEPTH_C) begin
						push_idx  = wrap(SUM_W'(oldest_q) + SUM_W'(count_q));
						nxt_count = count_q + CNT_W'(1);
					end else begin
						push_idx   = oldest_q;
						nxt_oldest = wrap(SUM_W'(oldest_q) + SUM_W'(1));
					end
					nxt_slot = push_idx;
				end
			end
			OP_RESTORE: begin
				if (count_q == '0 || work_q.blocked) begin
					nxt_status = ST_REJECTED;
				end else begin
					nxt_slot = top;
					nxt_lkey = '0;
					nxt_lval = 1'b0;
					if (work_q.ext_ok) begin
						nxt_ok     = 1'b1;
						nxt_status = ST_RESTORED;
						if (count_q == CNT_W'(1)) begin
							nxt_count  = '0;
							nxt_oldest = '0;
						end else begin
							nxt_count = count_q - CNT_W'(1);
						end
					end else begin
						nxt_status = ST_RESTORE_FAIL;
					end
				end
			end
			default: begin
				nxt_status = ST_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			oldest_q    <= '0;
			lkey_q      <= '0;
			lval_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_pop)
						state_q <= S_EXEC;
					if (out_valid_q && out_ready)
						out_valid_q <= 1'b0;
				end
				S_EXEC: begin
					state_q     <= S_IDLE;
					count_q     <= nxt_count;
					oldest_q    <= nxt_oldest;
					lkey_q      <= nxt_lkey;
					lval_q      <= nxt_lval;
					out_valid_q <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			work_q    <= q_data;
			rd_key_q  <= key_mem[top];
			rd_tick_q <= tick_mem[top];
		end
		if (state_q == S_EXEC) begin
			res_q.ok     <= nxt_ok;
			res_q.status <= nxt_status;
			res_q.slot   <= 4'(nxt_slot);
			res_q.levels <= 4'(nxt_count);
			res_q.avail  <= (nxt_count != '0);
			if (do_push) begin
				key_mem[push_idx]  <= cap_key;
				tick_mem[push_idx] <= work_q.now;
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count beyond ring depth");

	a_empty_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (oldest_q == '0))
		else $error("empty ring with non-zero oldest slot");

	a_exec_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> (!out_valid_q || out_ready))
		else $error("result would overwrite a pending beat");

	a_exec_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |=> (state_q == S_IDLE && out_valid_q))
		else $error("execution did not produce a result");
`endif

endmodule

@@ rtl/core/undo_history_ring_with_coalescing.sv @@
// undo_history_ring_with_coalescing: top level of the undo history ring
// front classifier, two-entry queue, back executor; depends on uhr_pkg
//
// usage:
//   input channel (in_valid/in_ready) carries one request beat: op, gest_id,
//   src_tag, cur_tick, blocked, external_ok
//   output channel (out_valid/out_ready) returns exactly one result beat per
//   request: ok, status, slot, levels_in_use, undo_available, in request order
//   cfg channel (cfg_valid/cfg_ready) writes coalesce_timeout; cfg_ready is
//   always high, write only while no request is outstanding
// flow: an accepted request waits in the queue; the back end pops it
//   and reads the top-slot memory in S_IDLE, then does the update and
//   result write in S_EXEC; it pops no new request until that one is
//   done, nor while a result is pending and out_ready is low
// reset: ring empty, no gesture key latched, timeout 300, no result pending
// stall: while out_ready is low the result is held; up to two further
//   requests wait in the queue, after which in_ready drops
module undo_history_ring_with_coalescing
	import uhr_pkg::*;
#(
	parameter int HISTORY_DEPTH = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] gest_id,
	input  logic [7:0]  src_tag,
	input  logic [31:0] cur_tick,
	input  logic        blocked,
	input  logic        external_ok,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic [2:0]  status,
	output logic [3:0]  slot,
	output logic [3:0]  levels_in_use,
	output logic        undo_available
);

	logic [15:0] timeout_q;
	logic        q_full;
	logic        q_empty;
	logic        q_push;
	logic        q_pop;
	item_t       q_in;
	item_t       q_out;
	result_t     res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			timeout_q <= TIMEOUT_RESET;
		else if (cfg_valid)
			timeout_q <= cfg_data;
	end

	uhr_front u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.gest_id     (gest_id),
		.src_tag     (src_tag),
		.cur_tick    (cur_tick),
		.blocked     (blocked),
		.external_ok (external_ok),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_in)
	);

	uhr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	uhr_back #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.timeout   (timeout_q),
		.q_empty   (q_empty),
		.q_data    (q_out),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign ok             = res.ok;
	assign status         = res.status;
	assign slot           = res.slot;
	assign levels_in_use  = res.levels;
	assign undo_available = res.avail;

endmodule
